@@ rtl/core/tcw_pkg.sv @@
// Shared types and constants for the text console writer.
// No dependencies; every other file in rtl/core depends on this package.
package tcw_pkg;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int ADDR_W     = 11;
    localparam int COL_W      = 7;
    localparam int ROW_W      = 5;
    localparam int CELL_W     = 16;

    localparam logic [1:0] CMD_PUT   = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0F20;
    localparam logic [7:0]        NEWLINE_CODE = 8'h0A;

    typedef logic [2:0] cursor_op_t;

    localparam cursor_op_t CUR_HOLD     = 3'd0;
    localparam cursor_op_t CUR_ADVANCE  = 3'd1;
    localparam cursor_op_t CUR_NEWLINE  = 3'd2;
    localparam cursor_op_t CUR_HOME     = 3'd3;
    localparam cursor_op_t CUR_LAST_ROW = 3'd4;

    typedef struct packed {
        logic [1:0]        command;
        logic [7:0]        char_code;
        logic [3:0]        background;
        logic [3:0]        foreground;
        logic [ADDR_W-1:0] cell_index;
    } cmd_t;

    typedef struct packed {
        logic [ADDR_W-1:0] cursor_offset;
        logic [COL_W-1:0]  cursor_column;
        logic [ROW_W-1:0]  cursor_row;
        logic              cell_written;
        logic [ADDR_W-1:0] write_index;
        logic [CELL_W-1:0] write_value;
        logic              scrolled;
        logic [CELL_W-1:0] read_value;
    } rsp_t;

    typedef struct packed {
        logic [ADDR_W-1:0] offset;
        logic [COL_W-1:0]  column;
        logic [ROW_W-1:0]  row;
    } cursor_t;

endpackage

@@ rtl/core/tcw_if.sv @@
// Valid/ready channel interfaces for console requests and results.
// Depends on tcw_pkg for the payload types.
interface tcw_cmd_if;
    logic          valid;
    logic          ready;
    tcw_pkg::cmd_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface tcw_rsp_if;
    logic          valid;
    logic          ready;
    tcw_pkg::rsp_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/core/tcw_cursor.sv @@
// Cursor register with offset, column and row kept side by side.
// Depends on tcw_pkg; updated by the sequencer in text_console_writer_top.
module tcw_cursor (
    input  logic                clk,
    input  logic                rst_n,
    input  tcw_pkg::cursor_op_t op,
    output tcw_pkg::cursor_t    cur,
    output tcw_pkg::cursor_t    cur_next
);
    import tcw_pkg::*;

    cursor_t          cur_reg;
    cursor_t          nxt;
    logic [ROW_W-1:0] line;
    logic [ROW_W-1:0] row_inc;

    always_comb
    begin
        // line holding the cell just before the cursor
        line = (cur_reg.column == '0 && cur_reg.offset != '0) ?
               cur_reg.row - ROW_W'(1) : cur_reg.row;
        row_inc = line + ROW_W'(1);
        nxt = cur_reg;
        case (op)
            CUR_ADVANCE:
            begin
                nxt.offset = cur_reg.offset + ADDR_W'(1);
                if (cur_reg.column == COL_W'(COLUMNS - 1))
                begin
                    nxt.column = '0;
                    nxt.row    = cur_reg.row + ROW_W'(1);
                end
                else
                begin
                    nxt.column = cur_reg.column + COL_W'(1);
                end
            end
            CUR_NEWLINE:
            begin
                nxt.offset = ADDR_W'(int'(row_inc) * COLUMNS);
                nxt.column = '0;
                nxt.row    = row_inc;
            end
            CUR_HOME:
            begin
                nxt = '0;
            end
            CUR_LAST_ROW:
            begin
                nxt.offset = ADDR_W'(CELL_COUNT - COLUMNS);
                nxt.column = '0;
                nxt.row    = ROW_W'(ROWS - 1);
            end
            default:
            begin
                nxt = cur_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg <= '0;
        end
        else
        begin
            cur_reg <= nxt;
        end
    end

    assign cur      = cur_reg;
    assign cur_next = nxt;

endmodule

@@ rtl/core/text_console_writer_top.sv @@
// Text console writer top level: cell store, sequencer and result register.
// Depends on tcw_pkg, tcw_if (tcw_cmd_if, tcw_rsp_if) and tcw_cursor.
//
// The block keeps a 25 x 80 store of 16-bit character cells in one memory
// with one write port and one registered read port, and answers every request
// with one result. After reset it sweeps the store to blank cells, one cell a
// cycle, with cmd.ready low. A put is accepted, then makes one store write and
// cursor update; a newline only updates the cursor; a read adds the registered
// memory read; command 3 goes through a finish state. A put with the cursor at
// end of screen first copies rows up through the single memory port, then
// blanks the last row, then stores at the start of the last row. A clear
// screen sweeps all 2000 cells to blank and homes the cursor. Results wait in
// an output register, so the next request is taken while an earlier result is
// still held.
module text_console_writer_top (
    input logic       clk,
    input logic       rst_n,
    tcw_cmd_if.sink   cmd,
    tcw_rsp_if.source rsp
);
    import tcw_pkg::*;

    localparam logic [2:0] S_INIT   = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_EXEC   = 3'd2;
    localparam logic [2:0] S_SCROLL = 3'd3;
    localparam logic [2:0] S_BLANK  = 3'd4;
    localparam logic [2:0] S_READ   = 3'd5;
    localparam logic [2:0] S_FIN    = 3'd6;

    logic [2:0]        state_reg, state_next;
    logic [ADDR_W-1:0] ptr_reg, ptr_next;
    logic              scrolled_reg, scrolled_next;
    cmd_t              req_reg;
    rsp_t              rsp_reg, rsp_fill;
    logic              rsp_valid_reg;
    logic              rsp_load;
    logic              out_free;
    logic              accept;

    logic [CELL_W-1:0] mem [CELL_COUNT];
    logic [CELL_W-1:0] rd_data_reg;
    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [CELL_W-1:0] mem_wdata;

    cursor_op_t        cur_op;
    cursor_t           cur, cur_next;

    tcw_cursor u_cursor (
        .clk      (clk),
        .rst_n    (rst_n),
        .op       (cur_op),
        .cur      (cur),
        .cur_next (cur_next)
    );

    assign out_free  = !rsp_valid_reg || rsp.ready;
    assign cmd.ready = (state_reg == S_IDLE);
    assign accept    = cmd.valid && cmd.ready;

    always_comb
    begin
        state_next    = state_reg;
        ptr_next      = ptr_reg;
        scrolled_next = scrolled_reg;
        mem_we        = 1'b0;
        mem_waddr     = ptr_reg;
        mem_wdata     = BLANK_CELL;
        mem_re        = 1'b0;
        mem_raddr     = ptr_reg;
        cur_op        = CUR_HOLD;
        rsp_load      = 1'b0;
        rsp_fill      = '0;

        case (state_reg)
            S_INIT:
            begin
                mem_we = 1'b1;
                if (ptr_reg == ADDR_W'(CELL_COUNT - 1))
                begin
                    ptr_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    ptr_next = ptr_reg + ADDR_W'(1);
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    scrolled_next = 1'b0;
                    state_next    = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (req_reg.command)
                    CMD_PUT:
                    begin
                        if (req_reg.char_code == NEWLINE_CODE)
                        begin
                            if (out_free)
                            begin
                                cur_op     = CUR_NEWLINE;
                                rsp_load   = 1'b1;
                                state_next = S_IDLE;
                            end
                        end
                        else if (cur.offset >= ADDR_W'(CELL_COUNT))
                        begin
                            ptr_next   = '0;
                            state_next = S_SCROLL;
                        end
                        else if (out_free)
                        begin
                            mem_we                = 1'b1;
                            mem_waddr             = cur.offset;
                            mem_wdata             = {req_reg.background, req_reg.foreground,
                                                     req_reg.char_code};
                            cur_op                = CUR_ADVANCE;
                            rsp_load              = 1'b1;
                            rsp_fill.cell_written = 1'b1;
                            rsp_fill.write_index  = cur.offset;
                            rsp_fill.write_value  = mem_wdata;
                            rsp_fill.scrolled     = scrolled_reg;
                            state_next            = S_IDLE;
                        end
                    end
                    CMD_READ:
                    begin
                        if (req_reg.cell_index < ADDR_W'(CELL_COUNT))
                        begin
                            mem_re     = 1'b1;
                            mem_raddr  = req_reg.cell_index;
                            state_next = S_READ;
                        end
                        else
                        begin
                            state_next = S_FIN;
                        end
                    end
                    CMD_CLEAR:
                    begin
                        ptr_next   = '0;
                        state_next = S_BLANK;
                    end
                    default:
                    begin
                        state_next = S_FIN;
                    end
                endcase
            end
            S_SCROLL:
            begin
                // read one row ahead, write the cell read last cycle
                if (ptr_reg < ADDR_W'(CELL_COUNT - COLUMNS))
                begin
                    mem_re    = 1'b1;
                    mem_raddr = ptr_reg + ADDR_W'(COLUMNS);
                end
                if (ptr_reg != '0)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = ptr_reg - ADDR_W'(1);
                    mem_wdata = rd_data_reg;
                end
                if (ptr_reg == ADDR_W'(CELL_COUNT - COLUMNS))
                begin
                    state_next = S_BLANK;
                end
                else
                begin
                    ptr_next = ptr_reg + ADDR_W'(1);
                end
            end
            S_BLANK:
            begin
                mem_we = 1'b1;
                if (ptr_reg == ADDR_W'(CELL_COUNT - 1))
                begin
                    ptr_next = '0;
                    if (req_reg.command == CMD_PUT)
                    begin
                        cur_op        = CUR_LAST_ROW;
                        scrolled_next = 1'b1;
                        state_next    = S_EXEC;
                    end
                    else
                    begin
                        cur_op     = CUR_HOME;
                        state_next = S_FIN;
                    end
                end
                else
                begin
                    ptr_next = ptr_reg + ADDR_W'(1);
                end
            end
            S_READ:
            begin
                if (out_free)
                begin
                    rsp_load            = 1'b1;
                    rsp_fill.read_value = rd_data_reg;
                    state_next          = S_IDLE;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    rsp_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        rsp_fill.cursor_offset = cur_next.offset;
        rsp_fill.cursor_column = cur_next.column;
        rsp_fill.cursor_row    = cur_next.row;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            ptr_reg       <= '0;
            scrolled_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            ptr_reg      <= ptr_next;
            scrolled_reg <= scrolled_next;
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= cmd.payload;
        end
        if (rsp_load)
        begin
            rsp_reg <= rsp_fill;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    assign rsp.valid   = rsp_valid_reg;
    assign rsp.payload = rsp_reg;

    a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> rsp.payload.cursor_offset <= ADDR_W'(CELL_COUNT))
        else $error("cursor offset beyond end of screen");

    a_cursor_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> 16'(rsp.payload.cursor_offset) ==
            16'(rsp.payload.cursor_row) * 16'(COLUMNS) + 16'(rsp.payload.cursor_column))
        else $error("cursor row and column disagree with offset");

    a_scroll_writes_last_row: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.payload.scrolled |->
            rsp.payload.cell_written &&
            rsp.payload.write_index == ADDR_W'(CELL_COUNT - COLUMNS))
        else $error("scroll did not store at start of last row");

    a_result_needs_request: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg) != S_IDLE && $past(state_reg) != S_INIT)
        else $error("result raised without a request in progress");

endmodule
